// File: rtl/core/wtrl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtrl_pkg
// Shared types, widths and the wait selection function of the wait time
// rule lookup unit.
// ---------------------------------------------------------------------------
package wtrl_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_W            = 17;
  localparam int PROV_W          = 25;
  localparam int SERV_W          = 17;
  localparam int WAIT_W          = 17;
  localparam int OUT_W           = 16;
  localparam int CNT_W           = 5;
  localparam int SLOT_W          = 4;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_t;

  typedef struct packed {
    logic signed [ID_W-1:0]   id;
    logic signed [PROV_W-1:0] provider;
    logic signed [SERV_W-1:0] service;
  } key_t;

  typedef struct packed {
    logic                   en;
    key_t                   key;
    logic signed [ID_W-1:0] mask;
  } key_wr_t;

  function automatic logic [OUT_W-1:0] sel_wait(
    input logic signed [WAIT_W-1:0] dyn,
    input logic signed [WAIT_W-1:0] fix,
    input logic                     client,
    input logic                     hit
  );
    logic signed [WAIT_W-1:0] r;
    if (fix > 0 && dyn <= 0) begin
      r = fix;
    end else if (!client) begin
      r = (dyn < 0) ? '0 : dyn;
    end else if (fix > 0 || dyn > 0) begin
      if (hit) begin
        r = (dyn >= fix) ? dyn : fix;
      end else begin
        r = (fix > 0) ? fix : '0;
      end
    end else begin
      r = '0;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/wtrl_rule_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wtrl_rule_table
// Key part of the rule table (id, mask, provider, service) with one
// compare lane per entry; gives the raw match vector and the default flag.
// ---------------------------------------------------------------------------
module wtrl_rule_table #(
  parameter int DEPTH = wtrl_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = 4
) (
  input  wire                        clk,
  input  wtrl_pkg::key_wr_t          wr,
  input  wire  [IDX_W-1:0]           wr_idx,
  input  wtrl_pkg::key_t             lk,
  input  wire  [wtrl_pkg::CNT_W-1:0] count,
  output logic [DEPTH-1:0]           match_o,
  output logic                       dflt_o
);
  import wtrl_pkg::*;

  logic signed [ID_W-1:0]   id_r   [DEPTH];
  logic signed [ID_W-1:0]   mask_r [DEPTH];
  logic signed [PROV_W-1:0] prov_r [DEPTH];
  logic signed [SERV_W-1:0] serv_r [DEPTH];

  logic signed [ID_W-1:0] id_hi;
  logic [ID_W-1:0]        id_bits;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_r[wr_idx]   <= wr.key.id;
      mask_r[wr_idx] <= wr.mask;
      prov_r[wr_idx] <= wr.key.provider;
      serv_r[wr_idx] <= wr.key.service;
    end
  end

  assign id_bits = lk.id;
  assign id_hi   = lk.id >>> 8;

  always_comb begin
    logic hit_id, hit_prov, hit_serv, m;
    for (int i = 0; i < DEPTH; i++) begin
      hit_id = (id_r[i] == lk.id) || (id_r[i] == id_hi) || (id_r[i] == -17'sd1) ||
               (!mask_r[i][ID_W-1] && ((id_bits & mask_r[i]) == id_r[i]));
      hit_prov = (prov_r[i] >= 0 && prov_r[i] == lk.provider) || (prov_r[i] == -25'sd1);
      hit_serv = (serv_r[i] >= 0 && serv_r[i] == lk.service) || (serv_r[i] == -17'sd1);
      m = hit_id && hit_prov && hit_serv && (i < int'(count));
      // rule 0 with a non-positive id is the default, never a match
      if (i == 0) begin
        match_o[i] = m && (id_r[0] > 0);
      end else begin
        match_o[i] = m;
      end
    end
  end

  assign dflt_o = (count != '0) && (id_r[0] <= 0);

endmodule
`default_nettype wire

// File: rtl/core/wait_time_rule_lookup_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wait_time_rule_lookup_unit
// Rule table with first-match lookup of the wait time per request.
// ---------------------------------------------------------------------------
// A request is taken on every clock edge where start is high; busy stays low,
// so one request per cycle is sustained. A load request writes one table
// slot and gives no result. A lookup request gives its wait time on
// out_delay_ms with out_valid high for one cycle, through three register
// stages: one stage compares all entries in parallel, one picks the first
// match and reads its waits, one applies the wait selection. Results leave
// in request order and cannot be held off. Load and lookup requests may be
// mixed freely; a lookup sees every load taken before it. The user must write
// entry_count through the cfg port while no lookup is in flight; not enforced.
// ---------------------------------------------------------------------------
module wait_time_rule_lookup_unit #(
  parameter int TABLE_DEPTH = wtrl_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_req_type,
  input  wire        [wtrl_pkg::SLOT_W-1:0]  in_entry_index,
  input  wire signed [wtrl_pkg::ID_W-1:0]    in_key_id,
  input  wire signed [wtrl_pkg::PROV_W-1:0]  in_key_provider,
  input  wire signed [wtrl_pkg::SERV_W-1:0]  in_key_service,
  input  wire signed [wtrl_pkg::ID_W-1:0]    in_entry_mask,
  input  wire signed [wtrl_pkg::WAIT_W-1:0]  in_entry_dyn_wait,
  input  wire signed [wtrl_pkg::WAIT_W-1:0]  in_entry_fixed_wait,
  input  wire                                in_has_client,
  input  wire                                in_cache_hit,
  output logic                               out_valid,
  output logic       [wtrl_pkg::OUT_W-1:0]   out_delay_ms,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire        [wtrl_pkg::CNT_W-1:0]   cfg_entry_count
);
  import wtrl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [TABLE_DEPTH-1:0] ONE = TABLE_DEPTH'(1);

  logic             accept;
  logic             is_lookup;
  logic [CNT_W-1:0] count_r;

  key_wr_t          key_wr;
  key_t             lk;
  logic [IDX_W-1:0] wr_idx;
  logic [TABLE_DEPTH-1:0] match;
  logic             dflt;

  // wait part of the table
  logic signed [WAIT_W-1:0] dyn_r [TABLE_DEPTH];
  logic signed [WAIT_W-1:0] fix_r [TABLE_DEPTH];

  // stage 1
  logic                     s1_vld_r;
  logic [TABLE_DEPTH-1:0]   s1_match_r;
  logic                     s1_dflt_r;
  logic                     s1_client_r;
  logic                     s1_hit_r;
  logic                     s1_ld_r;
  logic [IDX_W-1:0]         s1_ld_idx_r;
  logic signed [WAIT_W-1:0] s1_ld_dyn_r;
  logic signed [WAIT_W-1:0] s1_ld_fix_r;

  // stage 2
  logic [TABLE_DEPTH-1:0]   first_oh;
  logic signed [WAIT_W-1:0] dyn_nxt;
  logic signed [WAIT_W-1:0] fix_nxt;
  logic                     s2_vld_r;
  logic signed [WAIT_W-1:0] s2_dyn_r;
  logic signed [WAIT_W-1:0] s2_fix_r;
  logic                     s2_client_r;
  logic                     s2_hit_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_lookup = (req_type_t'(in_req_type) == REQ_LOOKUP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_entry_count;
    end
  end

  assign wr_idx          = IDX_W'(in_entry_index);
  assign key_wr.en       = accept && !is_lookup && (int'(in_entry_index) < TABLE_DEPTH);
  assign key_wr.key      = '{id: in_key_id, provider: in_key_provider, service: in_key_service};
  assign key_wr.mask     = in_entry_mask;
  assign lk              = key_wr.key;

  wtrl_rule_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr      (key_wr),
    .wr_idx  (wr_idx),
    .lk      (lk),
    .count   (count_r),
    .match_o (match),
    .dflt_o  (dflt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_ld_r  <= 1'b0;
    end else begin
      s1_vld_r <= accept && is_lookup;
      s1_ld_r  <= key_wr.en;
    end
  end

  always_ff @(posedge clk) begin
    s1_match_r  <= match;
    s1_dflt_r   <= dflt;
    s1_client_r <= in_has_client;
    s1_hit_r    <= in_cache_hit;
    s1_ld_idx_r <= wr_idx;
    s1_ld_dyn_r <= in_entry_dyn_wait;
    s1_ld_fix_r <= in_entry_fixed_wait;
  end

  // waits are written in the cycle after the keys, matching the stage where lookups read them
  always_ff @(posedge clk) begin
    if (s1_ld_r) begin
      dyn_r[s1_ld_idx_r] <= s1_ld_dyn_r;
      fix_r[s1_ld_idx_r] <= s1_ld_fix_r;
    end
  end

  assign first_oh = s1_match_r & ~(s1_match_r - ONE);

  always_comb begin
    logic signed [WAIT_W-1:0] d_or, f_or;
    d_or = '0;
    f_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      d_or = d_or | (dyn_r[i] & {WAIT_W{first_oh[i]}});
      f_or = f_or | (fix_r[i] & {WAIT_W{first_oh[i]}});
    end
    if (s1_match_r != '0) begin
      dyn_nxt = d_or;
      fix_nxt = f_or;
    end else if (s1_dflt_r) begin
      dyn_nxt = dyn_r[0];
      fix_nxt = fix_r[0];
    end else begin
      dyn_nxt = -17'sd1;
      fix_nxt = -17'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_dyn_r    <= dyn_nxt;
    s2_fix_r    <= fix_nxt;
    s2_client_r <= s1_client_r;
    s2_hit_r    <= s1_hit_r;
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_delay_ms <= sel_wait(s2_dyn_r, s2_fix_r, s2_client_r, s2_hit_r);
  end

  // assertions
  a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_req_type == REQ_LOOKUP, 3))
    else $error("result without a lookup request three cycles earlier");

  a_single_winner: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $onehot0(first_oh))
    else $error("more than one rule selected");

  a_empty_table_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(count_r == '0, 3)) |-> (out_delay_ms == '0))
    else $error("nonzero wait with no rules in use");

endmodule
`default_nettype wire
